// ===== rtl/core/acit_pkg.sv =====
`default_nettype none

package acit_pkg;

	// Item kinds carried in the slave tuser
	localparam logic [2:0] FN_BUS_READ  = 3'd0;
	localparam logic [2:0] FN_BUS_WRITE = 3'd1;
	localparam logic [2:0] FN_IDLE      = 3'd2;
	localparam logic [2:0] FN_HOST_WR   = 3'd3;
	localparam logic [2:0] FN_HOST_RD   = 3'd4;

	// I/O page register offsets
	localparam logic [3:0] REG_TEST    = 4'h0;
	localparam logic [3:0] REG_CONTROL = 4'h1;
	localparam logic [3:0] REG_DSPADDR = 4'h2;
	localparam logic [3:0] REG_DSPDATA = 4'h3;
	localparam logic [3:0] REG_PORT0   = 4'h4;
	localparam logic [3:0] REG_PORT1   = 4'h5;
	localparam logic [3:0] REG_PORT2   = 4'h6;
	localparam logic [3:0] REG_PORT3   = 4'h7;
	localparam logic [3:0] REG_AUX0    = 4'h8;
	localparam logic [3:0] REG_AUX1    = 4'h9;
	localparam logic [3:0] REG_TARGET0 = 4'ha;
	localparam logic [3:0] REG_TARGET1 = 4'hb;
	localparam logic [3:0] REG_TARGET2 = 4'hc;
	localparam logic [3:0] REG_OUT0    = 4'hd;
	localparam logic [3:0] REG_OUT1    = 4'he;
	localparam logic [3:0] REG_OUT2    = 4'hf;

	localparam int SLOW_TIMER_DIVIDE = 128;
	localparam int FAST_TIMER_DIVIDE = 16;
	localparam int NUM_TIMERS        = 3;

	localparam logic [7:0] TEST_RESET    = 8'h0a;
	localparam logic [7:0] RAM_OFF_VALUE = 8'h5a;

	localparam logic [7:0] BOOT_ROM [64] = '{
		8'hcd, 8'hef, 8'hbd, 8'he8, 8'h00, 8'hc6, 8'h1d, 8'hd0,
		8'hfc, 8'h8f, 8'haa, 8'hf4, 8'h8f, 8'hbb, 8'hf5, 8'h78,
		8'hcc, 8'hf4, 8'hd0, 8'hfb, 8'h2f, 8'h19, 8'heb, 8'hf4,
		8'hd0, 8'hfc, 8'h7e, 8'hf4, 8'hd0, 8'h0b, 8'he4, 8'hf5,
		8'hcb, 8'hf4, 8'hd7, 8'h00, 8'hfc, 8'hd0, 8'hf3, 8'hab,
		8'h01, 8'h10, 8'hef, 8'h7e, 8'hf4, 8'h10, 8'heb, 8'hba,
		8'hf6, 8'hda, 8'h00, 8'hba, 8'hf4, 8'hc4, 8'hf4, 8'hdd,
		8'h5d, 8'hd0, 8'hdb, 8'h1f, 8'h00, 8'h00, 8'hc0, 8'hff
	};

	typedef struct packed {
		logic       step;      // advance the prescaler by clocks
		logic [4:0] clocks;
		logic       gate_old;  // TEST timer gate before this item
		logic       test_wr;   // TEST written: resync with gate_new
		logic       gate_new;
		logic       ctrl_wr;
		logic       ctrl_bit;
		logic       tgt_wr;
		logic       read_clr;
		logic [7:0] data;
	} tmr_ctl_t;

	function automatic logic [4:0] cpu_clocks(input logic [1:0] ws);
		logic [4:0] c;
		unique case (ws)
			2'd0: c = 5'd2;
			2'd1: c = 5'd4;
			2'd2: c = 5'd10;
			default: c = 5'd20;
		endcase
		return c;
	endfunction

	function automatic logic [4:0] timer_clocks(input logic [1:0] ws);
		logic [4:0] c;
		unique case (ws)
			2'd0: c = 5'd2;
			2'd1: c = 5'd4;
			2'd2: c = 5'd8;
			default: c = 5'd16;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/acit_timer.sv =====
`default_nettype none

module acit_timer #(
	parameter int DIVIDE = acit_pkg::SLOW_TIMER_DIVIDE
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire acit_pkg::tmr_ctl_t ctl,
	output logic [3:0]              out_count   // after the prescaler step, before any clear
);

	localparam int CNT_W = $clog2(DIVIDE);
	localparam int SUM_W = CNT_W + 1;
	localparam logic [SUM_W-1:0] DIV_S = SUM_W'(DIVIDE);

	logic [CNT_W-1:0] pre_q, pre_d;
	logic             phase_q, phase_d;
	logic             edge_q, edge_d;
	logic             en_q, en_d;
	logic [7:0]       div_q, div_d;
	logic [7:0]       tgt_q, tgt_d;
	logic [3:0]       out_q, out_d;
	logic [SUM_W-1:0] sum;
	logic             wrap;
	logic             level1, fall1, level2, fall2;

	always_comb begin
		sum  = {1'b0, pre_q} + SUM_W'(ctl.clocks);
		wrap = ctl.step && (sum >= DIV_S);
		if (!ctl.step)
			pre_d = pre_q;
		else if (wrap)
			pre_d = CNT_W'(sum - DIV_S);
		else
			pre_d = CNT_W'(sum);
		phase_d = phase_q ^ wrap;

		edge_d = edge_q;
		div_d  = div_q;
		out_d  = out_q;

		// divider clocks on a falling edge of the gated prescaler phase
		level1 = phase_d & ctl.gate_old;
		fall1  = edge_d & ~level1;
		if (wrap) begin
			edge_d = level1;
			if (fall1 && en_q) begin
				div_d = div_d + 8'd1;
				if (div_d == tgt_q) begin
					div_d = '0;
					out_d = out_d + 4'd1;
				end
			end
		end
		out_count = out_d;

		// resync after a TEST write with the new gate
		level2 = phase_d & ctl.gate_new;
		fall2  = edge_d & ~level2;
		if (ctl.test_wr) begin
			edge_d = level2;
			if (fall2 && en_q) begin
				div_d = div_d + 8'd1;
				if (div_d == tgt_q) begin
					div_d = '0;
					out_d = out_d + 4'd1;
				end
			end
		end

		en_d = en_q;
		if (ctl.ctrl_wr) begin
			if (!en_q && ctl.ctrl_bit) begin
				div_d = '0;
				out_d = '0;
			end
			en_d = ctl.ctrl_bit;
		end

		tgt_d = ctl.tgt_wr ? ctl.data : tgt_q;
		if (ctl.read_clr)
			out_d = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_q   <= '0;
			phase_q <= 1'b0;
			edge_q  <= 1'b0;
			en_q    <= 1'b0;
			div_q   <= '0;
			tgt_q   <= '0;
			out_q   <= '0;
		end else begin
			pre_q   <= pre_d;
			phase_q <= phase_d;
			edge_q  <= edge_d;
			en_q    <= en_d;
			div_q   <= div_d;
			tgt_q   <= tgt_d;
			out_q   <= out_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/audio_cpu_io_and_timers_unit.sv =====
// I/O page and timers of an 8-bit sound processor.
// Slave stream: one item per bus read, bus write, idle cycle or host port
// access; tuser carries the kind, tdata the address, write byte, RAM byte,
// DSP byte and the direct-page flag. Master stream: one result per item with
// read data, RAM and DSP write enables, the DSP address and the processor
// clocks the access used.
// An accepted item is held in the input register and is then loaded into
// the result register, from which its result is offered on the master
// stream. Throughput is one item per cycle while the receiver does not stall;
// all register and timer updates are made as an item moves from the input
// register into the result register, so the next item sees them at once.
// When the receiver stalls, the result holds and the input register holds
// one more item; tready on the slave side drops only when both are full.
// Reset clears both stages and puts the TEST bits at RAM writable with
// timers enabled, the boot ROM mapped, and all ports, aux bytes and timers
// at zero.
`default_nettype none

module audio_cpu_io_and_timers_unit #(
	parameter int SLOW_DIVIDE = acit_pkg::SLOW_TIMER_DIVIDE,
	parameter int FAST_DIVIDE = acit_pkg::FAST_TIMER_DIVIDE
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// [15:0] address, [23:16] write_data, [31:24] ram_data,
	// [39:32] dsp_read_data, [40] p_flag, [47:41] zero
	input  wire  [47:0] s_axis_tdata,
	// [2:0] func
	input  wire  [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// [7:0] read_data, [8] ram_write_enable, [9] dsp_write_enable,
	// [16:10] dsp_address, [21:17] clocks_used, [23:22] zero
	output logic [23:0] m_axis_tdata
);

	// input stage
	logic        v_s1;
	logic [2:0]  func_s1;
	logic [15:0] addr_s1;
	logic [7:0]  wdata_s1, ram_s1, dsp_s1;
	logic        pf_s1;
	// result stage
	logic        v_s2;
	logic [23:0] res_s2;
	logic        adv;

	// state
	logic [7:0] test_q;
	logic       bre_q;
	logic [7:0] dsp_idx_q;
	logic [7:0] to_host_q   [4];
	logic [7:0] from_host_q [4];
	logic [7:0] aux_q       [2];

	assign adv           = v_s1 && (!v_s2 || m_axis_tready);
	assign s_axis_tready = !v_s1 || adv;
	assign m_axis_tvalid = v_s2;
	assign m_axis_tdata  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			func_s1  <= s_axis_tuser;
			addr_s1  <= s_axis_tdata[15:0];
			wdata_s1 <= s_axis_tdata[23:16];
			ram_s1   <= s_axis_tdata[31:24];
			dsp_s1   <= s_axis_tdata[39:32];
			pf_s1    <= s_axis_tdata[40];
		end
	end

	// decode
	logic       is_rd, is_wr, is_idle, is_hwr, is_hrd;
	logic       io_page, rom_hit;
	logic [3:0] reg_sel;
	logic [1:0] ws;
	logic       io_wr;
	logic       gate_old, gate_new;
	logic       test_wr;

	always_comb begin
		is_rd   = 1'b0;
		is_wr   = 1'b0;
		is_idle = 1'b0;
		is_hwr  = 1'b0;
		is_hrd  = 1'b0;
		unique case (func_s1)
			acit_pkg::FN_BUS_READ:  is_rd   = 1'b1;
			acit_pkg::FN_BUS_WRITE: is_wr   = 1'b1;
			acit_pkg::FN_IDLE:      is_idle = 1'b1;
			acit_pkg::FN_HOST_WR:   is_hwr  = 1'b1;
			acit_pkg::FN_HOST_RD:   is_hrd  = 1'b1;
			default: ;
		endcase
	end

	assign io_page  = addr_s1[15:4] == 12'h00f;
	assign rom_hit  = (addr_s1[15:6] == 10'h3ff) && bre_q;
	assign reg_sel  = addr_s1[3:0];
	assign ws       = ((io_page || rom_hit) && !is_idle) ? test_q[7:6] : test_q[5:4];
	assign io_wr    = adv && is_wr && io_page;
	assign test_wr  = io_wr && (reg_sel == acit_pkg::REG_TEST) && !pf_s1;
	assign gate_old = test_q[3] & ~test_q[0];
	assign gate_new = wdata_s1[3] & ~wdata_s1[0];

	// timers
	acit_pkg::tmr_ctl_t tctl [acit_pkg::NUM_TIMERS];
	logic [3:0]         tout [acit_pkg::NUM_TIMERS];

	for (genvar t = 0; t < acit_pkg::NUM_TIMERS; t++) begin : g_tmr
		always_comb begin
			tctl[t].step     = adv && (is_rd || is_wr || is_idle);
			tctl[t].clocks   = acit_pkg::timer_clocks(ws);
			tctl[t].gate_old = gate_old;
			tctl[t].test_wr  = test_wr;
			tctl[t].gate_new = gate_new;
			tctl[t].ctrl_wr  = io_wr && (reg_sel == acit_pkg::REG_CONTROL);
			tctl[t].ctrl_bit = wdata_s1[t];
			tctl[t].tgt_wr   = io_wr && (reg_sel == acit_pkg::REG_TARGET0 + 4'(t));
			tctl[t].read_clr = adv && is_rd && io_page
				&& (reg_sel == acit_pkg::REG_OUT0 + 4'(t));
			tctl[t].data     = wdata_s1;
		end

		acit_timer #(
			.DIVIDE((t == 2) ? FAST_DIVIDE : SLOW_DIVIDE)
		) u_tmr (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (tctl[t]),
			.out_count (tout[t])
		);
	end

	// result
	logic [7:0] io_rd, rd;
	logic       ram_we, dsp_we;
	logic [7:0] dsp_idx_next;
	logic [4:0] clk_used;

	always_comb begin
		case (reg_sel)
			acit_pkg::REG_DSPADDR: io_rd = dsp_idx_q;
			acit_pkg::REG_DSPDATA: io_rd = dsp_s1;
			acit_pkg::REG_PORT0, acit_pkg::REG_PORT1,
			acit_pkg::REG_PORT2, acit_pkg::REG_PORT3: io_rd = from_host_q[addr_s1[1:0]];
			acit_pkg::REG_AUX0, acit_pkg::REG_AUX1: io_rd = aux_q[addr_s1[0]];
			acit_pkg::REG_OUT0: io_rd = {4'h0, tout[0]};
			acit_pkg::REG_OUT1: io_rd = {4'h0, tout[1]};
			acit_pkg::REG_OUT2: io_rd = {4'h0, tout[2]};
			default: io_rd = 8'h00;
		endcase

		rd = 8'h00;
		if (is_rd) begin
			if (io_page)
				rd = io_rd;
			else if (rom_hit)
				rd = acit_pkg::BOOT_ROM[addr_s1[5:0]];
			else if (test_q[2])
				rd = acit_pkg::RAM_OFF_VALUE;
			else
				rd = ram_s1;
		end else if (is_hrd) begin
			rd = to_host_q[addr_s1[1:0]];
		end

		ram_we   = is_wr && test_q[1] && !test_q[2];
		dsp_we   = is_wr && io_page && (reg_sel == acit_pkg::REG_DSPDATA) && !dsp_idx_q[7];
		clk_used = (is_rd || is_wr || is_idle) ? acit_pkg::cpu_clocks(ws) : 5'd0;
		dsp_idx_next = (is_wr && io_page && (reg_sel == acit_pkg::REG_DSPADDR))
			? wdata_s1 : dsp_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= {2'b00, clk_used, dsp_idx_next[6:0], dsp_we, ram_we, rd};
	end

	// register file updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			test_q    <= acit_pkg::TEST_RESET;
			bre_q     <= 1'b1;
			dsp_idx_q <= '0;
			for (int i = 0; i < 4; i++) begin
				to_host_q[i]   <= '0;
				from_host_q[i] <= '0;
			end
			aux_q[0] <= '0;
			aux_q[1] <= '0;
		end else if (adv) begin
			dsp_idx_q <= dsp_idx_next;
			if (is_hwr)
				from_host_q[addr_s1[1:0]] <= wdata_s1;
			if (is_wr && io_page) begin
				case (reg_sel)
					acit_pkg::REG_TEST: begin
						if (!pf_s1)
							test_q <= wdata_s1;
					end
					acit_pkg::REG_CONTROL: begin
						if (wdata_s1[4]) begin
							from_host_q[0] <= '0;
							from_host_q[1] <= '0;
						end
						if (wdata_s1[5]) begin
							from_host_q[2] <= '0;
							from_host_q[3] <= '0;
						end
						bre_q <= wdata_s1[7];
					end
					acit_pkg::REG_PORT0, acit_pkg::REG_PORT1,
					acit_pkg::REG_PORT2, acit_pkg::REG_PORT3:
						to_host_q[addr_s1[1:0]] <= wdata_s1;
					acit_pkg::REG_AUX0, acit_pkg::REG_AUX1:
						aux_q[addr_s1[0]] <= wdata_s1;
					default: ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/acit_checker.sv =====
`default_nettype none

module acit_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_axis_tready,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [23:0] m_axis_tdata
);

	logic [4:0] clk_used;
	assign clk_used = m_axis_tdata[21:17];

	// a stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// only the wait-state clock counts or zero appear
	a_clocks_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> clk_used == 5'd0 || clk_used == 5'd2 || clk_used == 5'd4
			|| clk_used == 5'd10 || clk_used == 5'd20)
		else $error("illegal clocks_used");

	// a RAM write is a bus write: no read data, some clocks used
	a_ram_we_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tdata[7:0] == 8'h00 && clk_used != 5'd0)
		else $error("RAM write enable on a non-write result");

	// a DSP write is a bus write too
	a_dsp_we_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[9] |-> m_axis_tdata[7:0] == 8'h00 && clk_used != 5'd0)
		else $error("DSP write enable on a non-write result");

	// with room downstream the input side never backs up
	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

endmodule

bind audio_cpu_io_and_timers_unit acit_checker u_acit_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
